### sv/sorted_min_priority_queue_assert.svh
// assertion macros for the sorted min priority queue
// used by modules that check their own logic; needs clk and rst_n in scope
`ifndef SORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication
`define SMPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/smpq_pkg.sv
// types and codes for the sorted min priority queue
// no dependencies
`timescale 1ns / 1ps

package smpq_pkg;

  localparam int SMPQ_DEPTH = 16;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_PUSH = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] value;
  } smpq_in_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic [1:0]         status;
    logic [4:0]         held_count;
    logic               is_empty;
    logic               is_full;
  } smpq_out_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] key;
  } smpq_ctl_t;

endpackage

### sv/smpq_cell.sv
// one storage cell of the sorted chain: holds a key, shifts toward either neighbor
// depends on smpq_pkg
`timescale 1ns / 1ps

module smpq_cell import smpq_pkg::*; (
  input  logic               clk,
  input  smpq_ctl_t          ctl,
  input  logic               occ,
  input  logic               left_occ,
  input  logic               left_shift,
  input  logic signed [31:0] left_key,
  input  logic signed [31:0] right_key,
  output logic signed [31:0] key,
  output logic               shift
);

  logic signed [31:0] key_r;
  logic signed [31:0] key_nxt;

  // this cell's key moves up on a push
  assign shift = occ && (ctl.key < key_r);
  assign key   = key_r;

  always_comb begin
    key_nxt = key_r;
    case (ctl.op)
      OP_PUSH: begin
        if (left_shift) begin
          key_nxt = left_key;
        end else if (shift || (!occ && left_occ)) begin
          key_nxt = ctl.key;
        end
      end
      OP_POP: begin
        key_nxt = right_key;
      end
      default: begin
        key_nxt = key_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

### sv/sorted_min_priority_queue.sv
// Sorted min-first priority queue of up to DEPTH signed 32-bit keys, held in a
// chain of cells in ascending order. A push (cmd 0) inserts its key after equal
// keys; a pop (cmd 1) returns the smallest. Push when full gives overflow, pop
// when empty underflow, and the store is then unchanged. Each transaction yields
// one registered result in the cycle after acceptance; a new transaction is
// taken every cycle while the result register is free or being drained, since
// every cell updates at once from both neighbors. No clearing pass after reset.
// depends on smpq_pkg, smpq_cell and sorted_min_priority_queue_assert.svh
`timescale 1ns / 1ps

`include "sorted_min_priority_queue_assert.svh"

module sorted_min_priority_queue import smpq_pkg::*; #(
  parameter int DEPTH = SMPQ_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  smpq_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output smpq_out_t out_data
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic               out_valid_r;
  smpq_out_t          out_data_r;
  smpq_out_t          out_data_nxt;
  logic               accept;
  logic               is_full;
  logic               is_empty;
  smpq_ctl_t          ctl;
  logic [DEPTH-1:0]   occ;
  logic [DEPTH-1:0]   shift;
  logic signed [31:0] keys [DEPTH];
  logic [CW+4:0]      count_ext;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign is_full   = (count_r == CW'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    ctl.key = in_data.value;
    ctl.op  = OP_HOLD;
    if (accept) begin
      if (in_data.cmd == CMD_PUSH) begin
        if (!is_full) begin
          ctl.op = OP_PUSH;
        end
      end else if (!is_empty) begin
        ctl.op = OP_POP;
      end
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic               l_occ;
      logic               l_shift;
      logic signed [31:0] l_key;
      logic signed [31:0] r_key;

      assign occ[gi] = (count_r > CW'(gi));

      if (gi == 0) begin : g_first
        assign l_occ   = 1'b1;
        assign l_shift = 1'b0;
        assign l_key   = '0;
      end else begin : g_mid
        assign l_occ   = occ[gi-1];
        assign l_shift = shift[gi-1];
        assign l_key   = keys[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
        assign r_key = '0;
      end else begin : g_inner
        assign r_key = keys[gi+1];
      end

      smpq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occ        (occ[gi]),
        .left_occ   (l_occ),
        .left_shift (l_shift),
        .left_key   (l_key),
        .right_key  (r_key),
        .key        (keys[gi]),
        .shift      (shift[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    out_data_nxt.popped_value = '0;
    out_data_nxt.status       = STATUS_OK;
    case (ctl.op)
      OP_PUSH: begin
        count_nxt = count_r + CW'(1);
      end
      OP_POP: begin
        count_nxt = count_r - CW'(1);
        out_data_nxt.popped_value = keys[0];
      end
      default: begin
        if (in_data.cmd == CMD_PUSH) begin
          out_data_nxt.status = STATUS_OVERFLOW;
        end else begin
          out_data_nxt.status = STATUS_UNDERFLOW;
        end
      end
    endcase
    count_ext = {5'b0, count_nxt};
    out_data_nxt.held_count = count_ext[4:0];
    out_data_nxt.is_empty   = (count_nxt == '0);
    out_data_nxt.is_full    = (count_nxt == CW'(DEPTH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  // checks
  `SMPQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "count above depth")
  `SMPQ_ASSERT_NEXT(a_push_count, ctl.op == OP_PUSH, count_r == $past(count_r) + CW'(1), "push count")
  `SMPQ_ASSERT_NEXT(a_pop_head, ctl.op == OP_POP, out_data_r.popped_value == $past(keys[0]), "pop head")
  `SMPQ_ASSERT_NOW(a_no_move_idle, !accept, ctl.op == OP_HOLD, "cells moved without a transaction")
  `SMPQ_ASSERT_NOW(a_flags, out_valid_r, !(out_data_r.is_empty && out_data_r.is_full), "empty and full")

endmodule
